>>> sv/wsd_pkg.sv
`default_nettype none
package wsd_pkg;

  localparam int unsigned LEN_W   = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned OUT_W   = 80;  // fin + opcode + action + payload_len + data_byte
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // result kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // opcodes
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // actions
  localparam logic [2:0] ACT_DELIVER    = 3'd0;
  localparam logic [2:0] ACT_CLOSE      = 3'd1;
  localparam logic [2:0] ACT_IGNORE     = 3'd2;
  localparam logic [2:0] ACT_PONG       = 3'd3;
  localparam logic [2:0] ACT_DISCONNECT = 3'd4;

  // classified item handed from parser to output side
  typedef struct packed {
    logic              kind;
    logic              fin;
    logic [3:0]        opcode;
    logic              masked;
    logic [LEN_W-1:0]  payload_len;
    logic [BYTE_W-1:0] raw_byte;
    logic [BYTE_W-1:0] key_byte;
    logic              last;
  } wsd_entry_t;

endpackage
`default_nettype wire

>>> sv/websocket_frame_deframer_top.sv
`default_nettype none
// Channel   Dir  Signals                        Content
// in_       in   in_tvalid/in_tready/in_tdata   [7:0] stream_byte
// out_      out  out_tvalid/out_tready/out_*    tdata fin..data_byte, tuser kind, tlast last
// cfg_      in   cfg_valid/cfg_ready/cfg_data   [0] require_mask
//
// One byte accepted per cycle while in_tready is high; a result passes from its byte
// into the 4-entry queue, then into the output register.
// in_tready drops only when the queue is full, i.e. after sustained out_tready low.
// rst_n is synchronous, active low; require_mask comes up as 1.
// Header bytes that complete no header produce no item.
module websocket_frame_deframer_top
  import wsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [BYTE_W-1:0] in_tdata,    // [7:0] stream_byte
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata,   // [0] fin, [4:1] opcode, [7:5] action,
                                              // [71:8] payload_len, [79:72] data_byte
  output logic                   out_tuser,   // [0] kind: 0 header, 1 payload byte
  output logic                   out_tlast,
  // config write
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data     // [0] require_mask
);

  logic       req_mask_r, req_mask_nxt;
  logic       accept;
  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       pop;
  wsd_entry_t push_entry;
  wsd_entry_t head_entry;

  assign cfg_ready    = 1'b1;
  assign req_mask_nxt = (cfg_valid && cfg_ready) ? cfg_data : req_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_mask_r <= 1'b1;
    end else begin
      req_mask_r <= req_mask_nxt;
    end
  end

  // each byte yields at most one entry, so room for one is enough
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  wsd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .stream_byte (in_tdata),
    .push        (push),
    .entry       (push_entry)
  );

  wsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  // action and unmasking resolved on the way out
  wsd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .require_mask (req_mask_r),
    .head_valid   (q_valid),
    .head_entry   (head_entry),
    .pop          (pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast)
  );

endmodule
`default_nettype wire

>>> sv/wsd_front.sv
`default_nettype none
module wsd_front
  import wsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] stream_byte,
  output logic                   push,
  output wsd_entry_t             entry
);

  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_LEN7    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]        phase_r,    phase_nxt;
  logic              fin_r,      fin_nxt;
  logic [3:0]        opcode_r,   opcode_nxt;
  logic              masked_r,   masked_nxt;
  logic [3:0]        len_left_r, len_left_nxt;
  logic [LEN_W-1:0]  len_acc_r,  len_acc_nxt;
  logic [KEY_W-1:0]  key_r,      key_nxt;
  logic [2:0]        key_left_r, key_left_nxt;
  logic [LEN_W-1:0]  pay_left_r, pay_left_nxt;
  logic [1:0]        key_idx_r,  key_idx_nxt;

  logic              hdr_done;   // header complete on this byte
  logic [LEN_W-1:0]  hdr_len;
  logic [6:0]        len7;
  logic [3:0]        len_left_dec;
  logic [2:0]        key_left_dec;
  logic [BYTE_W-1:0] key_sel;

  assign len7         = stream_byte[6:0];
  assign len_left_dec = (len_left_r != 4'd0) ? len_left_r - 4'd1 : 4'd0;
  assign key_left_dec = (key_left_r != 3'd0) ? key_left_r - 3'd1 : 3'd0;

  // key byte 0 sits in the top byte
  always_comb begin
    case (key_idx_r)
      2'd0:    key_sel = key_r[31:24];
      2'd1:    key_sel = key_r[23:16];
      2'd2:    key_sel = key_r[15:8];
      default: key_sel = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    fin_nxt      = fin_r;
    opcode_nxt   = opcode_r;
    masked_nxt   = masked_r;
    len_left_nxt = len_left_r;
    len_acc_nxt  = len_acc_r;
    key_nxt      = key_r;
    key_left_nxt = key_left_r;
    pay_left_nxt = pay_left_r;
    key_idx_nxt  = key_idx_r;
    hdr_done     = 1'b0;
    hdr_len      = len_acc_r;
    push         = 1'b0;

    entry             = '0;
    entry.fin         = fin_r;
    entry.opcode      = opcode_r;
    entry.masked      = masked_r;
    entry.payload_len = len_acc_r;

    if (accept) begin
      unique case (phase_r)
        PH_LEN7: begin
          masked_nxt  = stream_byte[7];
          len_acc_nxt = '0;
          if (len7 == 7'd126) begin
            len_left_nxt = 4'd2;
            phase_nxt    = PH_EXTLEN;
          end else if (len7 == 7'd127) begin
            len_left_nxt = 4'd8;
            phase_nxt    = PH_EXTLEN;
          end else begin
            len_acc_nxt = {{(LEN_W-7){1'b0}}, len7};
            if (stream_byte[7]) begin
              key_left_nxt = 3'd4;
              key_nxt      = '0;
              phase_nxt    = PH_KEY;
            end else begin
              hdr_done = 1'b1;
              hdr_len  = len_acc_nxt;
            end
          end
        end
        PH_EXTLEN: begin
          len_acc_nxt  = {len_acc_r[LEN_W-BYTE_W-1:0], stream_byte};
          len_left_nxt = len_left_dec;
          if (len_left_dec == 4'd0) begin
            if (masked_r) begin
              key_left_nxt = 3'd4;
              key_nxt      = '0;
              phase_nxt    = PH_KEY;
            end else begin
              hdr_done = 1'b1;
              hdr_len  = len_acc_nxt;
            end
          end
        end
        PH_KEY: begin
          key_nxt      = {key_r[KEY_W-BYTE_W-1:0], stream_byte};
          key_left_nxt = key_left_dec;
          if (key_left_dec == 3'd0) begin
            hdr_done = 1'b1;
            hdr_len  = len_acc_r;
          end
        end
        PH_PAYLOAD: begin
          push           = 1'b1;
          entry.kind     = KIND_PAYLOAD;
          entry.raw_byte = stream_byte;
          entry.key_byte = key_sel;
          entry.last     = (pay_left_r <= {{(LEN_W-1){1'b0}}, 1'b1});
          key_idx_nxt    = key_idx_r + 2'd1;
          pay_left_nxt   = (pay_left_r != '0) ? pay_left_r - 1'b1 : '0;
          if (entry.last) begin
            phase_nxt = PH_FIRST;
          end
        end
        default: begin
          fin_nxt    = stream_byte[7];
          opcode_nxt = stream_byte[3:0];
          phase_nxt  = PH_LEN7;
        end
      endcase

      if (hdr_done) begin
        push              = 1'b1;
        entry.kind        = KIND_HEADER;
        entry.masked      = masked_nxt;
        entry.payload_len = hdr_len;
        entry.last        = (hdr_len == '0);
        pay_left_nxt      = hdr_len;
        key_idx_nxt       = 2'd0;
        phase_nxt         = (hdr_len == '0) ? PH_FIRST : PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIRST;
      fin_r      <= 1'b0;
      opcode_r   <= 4'd0;
      masked_r   <= 1'b0;
      len_left_r <= 4'd0;
      len_acc_r  <= '0;
      key_r      <= '0;
      key_left_r <= 3'd0;
      pay_left_r <= '0;
      key_idx_r  <= 2'd0;
    end else begin
      phase_r    <= phase_nxt;
      fin_r      <= fin_nxt;
      opcode_r   <= opcode_nxt;
      masked_r   <= masked_nxt;
      len_left_r <= len_left_nxt;
      len_acc_r  <= len_acc_nxt;
      key_r      <= key_nxt;
      key_left_r <= key_left_nxt;
      pay_left_r <= pay_left_nxt;
      key_idx_r  <= key_idx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_empty_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    push && (entry.kind == KIND_HEADER) && (entry.payload_len == '0) |-> entry.last)
    else $error("empty frame header without last");
  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (pay_left_r != '0))
    else $error("payload phase with nothing left");
`endif

endmodule
`default_nettype wire

>>> sv/wsd_queue.sv
`default_nettype none
module wsd_queue
  import wsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire wsd_entry_t push_entry,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output wsd_entry_t      head_entry
);

  wsd_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue pop while empty");
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers out of step with count");
`endif

endmodule
`default_nettype wire

>>> sv/wsd_back.sv
`default_nettype none
module wsd_back
  import wsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              require_mask,
  input  wire logic              head_valid,
  input  wire wsd_entry_t        head_entry,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic              valid_r, valid_nxt;
  logic [OUT_W-1:0]  data_r;
  logic              user_r;
  logic              last_r;
  logic [2:0]        action;
  logic [BYTE_W-1:0] data_byte;

  always_comb begin
    if (require_mask && !head_entry.masked) begin
      action = ACT_DISCONNECT;
    end else begin
      unique case (head_entry.opcode) inside
        OP_TEXT, OP_BINARY: action = ACT_DELIVER;
        OP_CLOSE:           action = ACT_CLOSE;
        OP_PING:            action = ACT_IGNORE;
        OP_PONG:            action = ACT_PONG;
        default:            action = ACT_DISCONNECT;
      endcase
    end
  end

  assign data_byte = head_entry.masked ? (head_entry.raw_byte ^ head_entry.key_byte)
                                       : head_entry.raw_byte;

  assign pop       = head_valid && (!valid_r || out_tready);
  assign valid_nxt = pop ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= {data_byte, head_entry.payload_len, action,
                 head_entry.opcode, head_entry.fin};
      user_r <= head_entry.kind;
      last_r <= head_entry.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire
